@@ src/xxtea_pkg.sv @@
`default_nettype none
package xxtea_pkg;

    localparam int WORD_W = 32;
    localparam int IO_WORDS = 4;
    localparam int KEY_WORDS = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word DELTA = 32'h9E37_79B9;
    localparam t_word KEY_RESET = 32'hFFFF_FFFF;
    localparam int BASE_ROUNDS = 6;
    localparam int ROUND_SPREAD = 52;

    typedef struct packed {
        t_word plain_word0;
        t_word plain_word1;
        t_word plain_word2;
        t_word plain_word3;
    } t_in;

    typedef struct packed {
        t_word cipher_word0;
        t_word cipher_word1;
        t_word cipher_word2;
        t_word cipher_word3;
    } t_out;

endpackage
`default_nettype wire

@@ src/xxtea_block_encrypt.sv @@
`default_nettype none
// XXTEA encryption of one block of BLOCK_WORDS 32-bit words (4 by default)
// under the 128-bit key in configuration registers 0 to 3 (reset to all ones).
// Words are taken big-endian from the packet bytes and returned the same way;
// words beyond plain_word3 enter as zero, and result fields beyond the block
// return their input words. A single mix-and-add datapath updates one word
// per cycle while the words rotate through a register ring; once all rounds
// are done the result is loaded into the output register, and only then is
// the next request taken. The block takes the next request while a finished
// result waits at the output; a finished block then holds until that result
// is taken.
module xxtea_block_encrypt #(
    parameter int BLOCK_WORDS = 4
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [xxtea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire xxtea_pkg::t_word       i_cfg_data,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire xxtea_pkg::t_in         i_in,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output xxtea_pkg::t_out             o_out
);
    import xxtea_pkg::*;

    localparam int ROUNDS = BASE_ROUNDS + ROUND_SPREAD / BLOCK_WORDS;
    localparam int P_W = $clog2(BLOCK_WORDS);
    localparam int R_W = $clog2(ROUNDS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [P_W-1:0] r_p;
    logic [R_W-1:0] r_round;
    t_word r_sum;
    t_word r_v [BLOCK_WORDS];
    t_word r_key [KEY_WORDS];
    t_in r_pass;
    t_out r_out;
    logic r_out_valid;

    t_word in_w [IO_WORDS];
    t_word pass_w [IO_WORDS];
    t_word res_w [IO_WORDS];

    t_word z, y, cur, mix_a, mix_b, n_word;
    logic [P_W+1:0] p_wide;
    logic [1:0] key_idx;
    logic last_p, last_round, in_acc, out_acc, load_out;

    assign in_w[0] = i_in.plain_word0;
    assign in_w[1] = i_in.plain_word1;
    assign in_w[2] = i_in.plain_word2;
    assign in_w[3] = i_in.plain_word3;
    assign pass_w[0] = r_pass.plain_word0;
    assign pass_w[1] = r_pass.plain_word1;
    assign pass_w[2] = r_pass.plain_word2;
    assign pass_w[3] = r_pass.plain_word3;

    // result words: cipher words inside the block, input words past it
    for (genvar gi = 0; gi < IO_WORDS; gi++) begin : g_res
        if (gi < BLOCK_WORDS) begin : g_blk
            assign res_w[gi] = r_v[gi];
        end else begin : g_pass
            assign res_w[gi] = pass_w[gi];
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = r_out_valid && i_out_ready;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // ring taps: current word, its successor, and the word updated last
    assign cur = r_v[0];
    assign y   = r_v[1];
    assign z   = r_v[BLOCK_WORDS-1];

    assign p_wide  = (P_W+2)'(r_p);
    assign key_idx = p_wide[1:0] ^ r_sum[3:2];
    assign mix_a   = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    assign mix_b   = (r_sum ^ y) + (r_key[key_idx] ^ z);
    assign n_word  = cur + (mix_a ^ mix_b);

    assign last_p     = (r_p == P_W'(BLOCK_WORDS - 1));
    assign last_round = (r_round == R_W'(ROUNDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= KEY_RESET;
            end
        end else if (i_cfg_valid) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_p         <= '0;
            r_round     <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_RUN;
                        r_p     <= '0;
                        r_round <= '0;
                    end
                end
                ST_RUN: begin
                    if (last_p) begin
                        r_p <= '0;
                        if (last_round) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_round <= r_round + 1'b1;
                        end
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pass <= i_in;
            r_sum  <= DELTA;
            for (int k = 0; k < BLOCK_WORDS; k++) begin
                r_v[k] <= (k < IO_WORDS) ? in_w[k % IO_WORDS] : '0;
            end
        end else if (r_state == ST_RUN) begin
            // rotate the ring; the updated word goes to the tail
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                r_v[k] <= r_v[k+1];
            end
            r_v[BLOCK_WORDS-1] <= n_word;
            if (last_p) begin
                r_sum <= r_sum + DELTA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.cipher_word0 <= res_w[0];
            r_out.cipher_word1 <= res_w[1];
            r_out.cipher_word2 <= res_w[2];
            r_out.cipher_word3 <= res_w[3];
        end
    end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xxtea_pkg::*;

    localparam int BLOCK_N = 4;
    localparam int RANDOM_PER_PHASE = 330;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_cfg_reg;

    logic i_clk;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_word cfg_data = '0;
    logic in_valid = 1'b0;
    t_in in_payload = '0;
    logic out_ready = 1'b0;

    logic o_cfg_ready;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    t_word key_shadow [KEY_WORDS];
    t_out pending_cipher [$];
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    xxtea_block_encrypt DUT (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in(in_payload),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("xxtea_block_encrypt: mismatch");
        $finish;
    end

    function automatic t_out xxtea_encrypt(t_in blk);
        t_word v [BLOCK_N];
        t_word sum;
        t_word z;
        t_word y;
        t_word a;
        t_word b;
        int unsigned rounds;
        int unsigned e;
        int unsigned k;
        t_out res;
        v[0] = blk.plain_word0;
        v[1] = blk.plain_word1;
        v[2] = blk.plain_word2;
        v[3] = blk.plain_word3;
        rounds = BASE_ROUNDS + ROUND_SPREAD / BLOCK_N;
        sum = '0;
        z = v[BLOCK_N-1];
        for (int r = 0; r < rounds; r++) begin
            sum = sum + DELTA;
            e = (sum >> 2) & 3;
            for (int p = 0; p < BLOCK_N; p++) begin
                // last word wraps around to word 0
                y = v[(p + 1) % BLOCK_N];
                k = (p & 3) ^ e;
                a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
                b = (sum ^ y) + (key_shadow[k] ^ z);
                v[p] = v[p] + (a ^ b);
                z = v[p];
            end
        end
        res.cipher_word0 = v[0];
        res.cipher_word1 = v[1];
        res.cipher_word2 = v[2];
        res.cipher_word3 = v[3];
        return res;
    endfunction

    function automatic t_word random_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_error(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : cipher_check
        t_out want;
        logic [4*WORD_W-1:0] got_bits;
        logic [4*WORD_W-1:0] want_bits;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_cipher.size() == 0) begin
                report_error($sformatf("unexpected result %h", o_out));
            end else begin
                want = pending_cipher.pop_front();
                got_bits = o_out;
                want_bits = want;
                for (int i = 0; i < IO_WORDS; i++) begin
                    if (got_bits[4*WORD_W-1-WORD_W*i -: WORD_W] !==
                        want_bits[4*WORD_W-1-WORD_W*i -: WORD_W]) begin
                        report_error($sformatf("cipher_word%0d got %h want %h", i,
                            got_bits[4*WORD_W-1-WORD_W*i -: WORD_W],
                            want_bits[4*WORD_W-1-WORD_W*i -: WORD_W]));
                    end
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_block(t_in blk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_payload <= blk;
        do @(posedge i_clk); while (!o_in_ready);
        pending_cipher.push_back(xxtea_encrypt(blk));
        @(negedge i_clk);
    endtask

    // valid stays high between back-to-back writes; the caller drops it
    task automatic write_cfg(t_cfg_reg idx, t_word data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_shadow[idx] = data;
        @(negedge i_clk);
    endtask

    task automatic load_key(t_word k0, t_word k1, t_word k2, t_word k3);
        write_cfg(REG_KEY0, k0);
        write_cfg(REG_KEY1, k1);
        write_cfg(REG_KEY2, k2);
        write_cfg(REG_KEY3, k3);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cipher.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_directed_set();
        send_block('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_block('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_block('{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
        send_block('{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
        send_block('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
        send_block('{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});
        wait_drained();
    endtask

    task automatic test_reset_key();
        send_directed_set();
    endtask

    task automatic test_key_extremes();
        load_key('0, '0, '0, '0);
        send_directed_set();
        load_key('1, '1, '1, '1);
        send_directed_set();
        // distinct words catch a swapped key index
        load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_directed_set();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int count);
        t_in blk;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int half = 0; half < 2; half++) begin
            load_key(random_word(), random_word(), random_word(), random_word());
            for (int n = 0; n < count / 2; n++) begin
                blk.plain_word0 = random_word();
                blk.plain_word1 = random_word();
                blk.plain_word2 = random_word();
                blk.plain_word3 = random_word();
                send_block(blk);
            end
            wait_drained();
        end
    endtask

    initial begin
        for (int i = 0; i < KEY_WORDS; i++) key_shadow[i] = KEY_RESET;
        repeat (3) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_key();
        test_key_extremes();
        test_random_traffic(8, 52, RANDOM_PER_PHASE);
        test_random_traffic(52, 8, RANDOM_PER_PHASE);
        test_random_traffic(0, 0, RANDOM_PER_PHASE);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("xxtea_block_encrypt: match");
        end else begin
            $display("xxtea_block_encrypt: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/xxtea_pkg.sv
src/xxtea_block_encrypt.sv
tb/testbench.sv
